>>> src/cbst_pkg.sv
// Shared types and constants for the conditional block skip tracker.
package cbst_pkg;

  localparam int COUNT_W    = 8;
  localparam int FILE_DEPTH = 8;
  localparam int LEVEL_W    = $clog2(FILE_DEPTH + 1);
  localparam int ADDR_W     = (FILE_DEPTH > 1) ? $clog2(FILE_DEPTH) : 1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_START_CFG,
    OP_START_FILE,
    OP_END_FILE,
    OP_IF,
    OP_ELSEIF,
    OP_ELSE,
    OP_ENDIF,
    OP_LINE
  } op_t;

  typedef enum logic [1:0] {
    KIND_COND,
    KIND_ELSE,
    KIND_SKIP
  } kind_t;

  typedef enum logic [1:0] {
    RES_TRUE,
    RES_FALSE,
    RES_ERROR,
    RES_NOTEVAL
  } res_t;

  typedef enum logic [2:0] {
    WARN_NONE,
    WARN_ELSEIF_NO_IF,
    WARN_ELSE_NO_IF,
    WARN_ENDIF_NO_IF,
    WARN_INCLUDE_FALSE,
    WARN_UNCLOSED_IF,
    WARN_STACK_FAULT
  } warn_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

endpackage

>>> src/cbst_stack.sv
// File stack of saved true counts: synchronous memory with a cached top entry.
module cbst_stack
  import cbst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stack_req_t  req,
  input  count_t      push_data,
  output stack_stat_t stat,
  output count_t      top
);

  count_t                 mem [FILE_DEPTH];
  count_t                 rd_data;
  level_t                 level;
  level_t                 level_next;
  logic   [ADDR_W-1:0]    rd_addr;
  logic   [LEVEL_W:0]     below_top;

  always_comb begin
    level_next = level;
    if (req.clear) begin
      level_next = '0;
    end else if (req.push) begin
      level_next = level + 1'b1;
    end else if (req.pop) begin
      level_next = level - 1'b1;
    end
  end

  // Prefetch the entry under the new top so a pop can refill the cache at once
  assign below_top = {1'b0, level_next} - (LEVEL_W + 1)'(2);
  assign rd_addr   = below_top[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[level[ADDR_W-1:0]] <= push_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      top <= push_data;
    end else if (req.pop) begin
      top <= rd_data;
    end
  end

  assign stat.empty = (level == '0);
  assign stat.full  = (level == LEVEL_W'(FILE_DEPTH));

endmodule

>>> src/conditional_block_skip_tracker.sv
// Top level of the conditional block skip tracker.
// Takes one line event per cycle and returns one result per event in the next
// cycle, from an output register; an event is taken in every cycle in which
// the output register is empty or being drained. Counts of open true and
// false branches and the pending-else flag sit in registers; the saved true
// counts of nested files sit in a small synchronous memory whose top entry is
// cached, with the entry below it read ahead, so an end of file restores its
// count without a stall. No clearing pass is needed after reset.
module conditional_block_skip_tracker
  import cbst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  logic       cond_true,
  input  logic       cond_error,
  input  logic       line_not_reportable,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       skip_line,
  output logic       trace_valid,
  output logic [1:0] trace_kind,
  output logic [1:0] trace_result,
  output logic       trace_active,
  output logic [2:0] warning
);

  count_t      open_true;
  count_t      open_false;
  logic        else_pending;
  count_t      open_true_next;
  count_t      open_false_next;
  logic        else_pending_next;
  logic        accept;
  stack_req_t  req;
  stack_req_t  stack_req;
  stack_stat_t stat;
  count_t      top;
  logic        traced;
  kind_t       kind;
  res_t        res;
  logic        act;
  warn_t       warn;
  logic        skip;
  logic        take;

  function automatic count_t inc_sat(count_t v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign stack_req = accept ? req : '0;

  cbst_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .req       (stack_req),
    .push_data (open_true),
    .stat      (stat),
    .top       (top)
  );

  always_comb begin
    open_true_next    = open_true;
    open_false_next   = open_false;
    else_pending_next = else_pending;
    req               = '0;
    traced            = 1'b0;
    kind              = KIND_COND;
    res               = RES_TRUE;
    act               = 1'b0;
    warn              = WARN_NONE;
    skip              = 1'b0;
    take              = 1'b0;
    case (op_t'(op))
      OP_START_CFG: begin
        open_true_next  = '0;
        open_false_next = '0;
        req.clear       = 1'b1;
      end
      OP_START_FILE: begin
        if (open_false != '0) begin
          warn            = WARN_INCLUDE_FALSE;
          open_false_next = '0;
        end
        if (!stat.full) begin
          req.push = 1'b1;
        end else begin
          warn = WARN_STACK_FAULT;
        end
        open_true_next    = '0;
        else_pending_next = 1'b0;
      end
      OP_END_FILE: begin
        if (open_true != '0 || open_false != '0) begin
          warn            = WARN_UNCLOSED_IF;
          open_false_next = '0;
        end
        if (!stat.empty) begin
          req.pop        = 1'b1;
          open_true_next = top;
        end else begin
          open_true_next = '0;
          warn           = WARN_STACK_FAULT;
        end
      end
      default: begin
        case (op_t'(op))
          OP_IF: begin
            if (open_false == '0) begin
              traced = 1'b1;
              kind   = KIND_COND;
              if (cond_error) begin
                res             = RES_ERROR;
                open_false_next = inc_sat(open_false);
              end else if (cond_true) begin
                res            = RES_TRUE;
                act            = 1'b1;
                open_true_next = inc_sat(open_true);
              end else begin
                res               = RES_FALSE;
                open_false_next   = inc_sat(open_false);
                else_pending_next = 1'b1;
              end
            end else begin
              open_false_next = inc_sat(open_false);
            end
          end
          OP_ELSEIF, OP_ELSE: begin
            kind = (op_t'(op) == OP_ELSE) ? KIND_ELSE : KIND_COND;
            if (open_false == '0) begin
              traced = 1'b1;
              res    = RES_NOTEVAL;
              if (open_true == '0) begin
                warn = (op_t'(op) == OP_ELSE) ? WARN_ELSE_NO_IF : WARN_ELSEIF_NO_IF;
              end else begin
                open_false_next = inc_sat(open_false);
                open_true_next  = open_true - 1'b1;
              end
            end else if (open_false == COUNT_W'(1)) begin
              traced = 1'b1;
              res    = RES_NOTEVAL;
              // A branch can still be taken only while the chain is pending
              if (else_pending) begin
                if (op_t'(op) == OP_ELSE) begin
                  take = 1'b1;
                end else if (cond_error) begin
                  res = RES_ERROR;
                end else begin
                  res  = cond_true ? RES_TRUE : RES_FALSE;
                  take = cond_true;
                end
                if (take) begin
                  act               = 1'b1;
                  open_false_next   = '0;
                  open_true_next    = inc_sat(open_true);
                  else_pending_next = 1'b0;
                end
              end
            end
          end
          OP_ENDIF: begin
            if (open_false == '0) begin
              if (open_true == '0) begin
                warn = WARN_ENDIF_NO_IF;
              end else begin
                open_true_next = open_true - 1'b1;
              end
            end else begin
              open_false_next = open_false - 1'b1;
            end
            if (open_false_next == '0) begin
              else_pending_next = 1'b0;
            end
          end
          default: begin
          end
        endcase
        if (open_false_next != '0) begin
          skip = 1'b1;
          if (!traced && !line_not_reportable) begin
            traced = 1'b1;
            kind   = KIND_SKIP;
            res    = RES_NOTEVAL;
            act    = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_true    <= '0;
      open_false   <= '0;
      else_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        open_true    <= open_true_next;
        open_false   <= open_false_next;
        else_pending <= else_pending_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (accept) begin
      skip_line    <= skip;
      trace_valid  <= traced;
      trace_kind   <= traced ? kind : KIND_COND;
      trace_result <= traced ? res : RES_TRUE;
      trace_active <= traced && act;
      warning      <= warn;
    end
  end

endmodule

>>> src/cbst_checker.sv
// Port-level checks for the conditional block skip tracker, bound to the top level.
module cbst_checker
  import cbst_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       skip_line,
  input logic       trace_valid,
  input logic [1:0] trace_kind,
  input logic [1:0] trace_result,
  input logic       trace_active,
  input logic [2:0] warning
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(skip_line) && $stable(trace_valid)
      && $stable(trace_kind) && $stable(trace_result) && $stable(trace_active)
      && $stable(warning))
    else $error("stalled result changed");

  a_no_trace_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !trace_valid |-> trace_kind == KIND_COND && trace_result == RES_TRUE
      && !trace_active)
    else $error("trace fields set without a trace entry");

  a_skip_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && trace_valid && trace_kind == KIND_SKIP |-> skip_line
      && trace_result == RES_NOTEVAL && !trace_active)
    else $error("skipped-line entry inconsistent");

  a_active_not_skipped: assert property (@(posedge clk) disable iff (rst)
    out_valid && trace_active |-> !skip_line)
    else $error("active branch reported as skipped");

  a_file_warning: assert property (@(posedge clk) disable iff (rst)
    out_valid && (warning == WARN_INCLUDE_FALSE || warning == WARN_UNCLOSED_IF
      || warning == WARN_STACK_FAULT) |-> !skip_line && !trace_valid)
    else $error("file event produced a trace or a skip");

endmodule

bind conditional_block_skip_tracker cbst_checker u_cbst_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .skip_line    (skip_line),
  .trace_valid  (trace_valid),
  .trace_kind   (trace_kind),
  .trace_result (trace_result),
  .trace_active (trace_active),
  .warning      (warning)
);
